FILE: hw/rtl/ppmd_pkg.sv
// PPM stream decoder package: parse phases, controller states, codes,
// command and status structs, and character class helpers.
// No dependencies.
package ppmd_pkg;

	localparam int NUMBER_BITS_DEF = 16;
	localparam int OUT_DATA_W      = 112;

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_3    = 8'h33;
	localparam logic [7:0] CH_6    = 8'h36;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_NL   = 8'h0A;

	typedef enum logic [3:0] {
		PH_BEGIN   = 4'd0,
		PH_FORMAT  = 4'd1,
		PH_WIDTH   = 4'd2,
		PH_HEIGHT  = 4'd3,
		PH_MAXVAL  = 4'd4,
		PH_EOL     = 4'd5,
		PH_SKIP    = 4'd6,
		PH_COMMENT = 4'd7,
		PH_PIXSKIP = 4'd8,
		PH_RED     = 4'd9,
		PH_GREEN   = 4'd10,
		PH_BLUE    = 4'd11,
		PH_RAW     = 4'd12
	} phase_t;

	typedef enum logic [1:0] {CS_IDLE, CS_START, CS_WAIT} ctl_state_t;

	typedef enum logic [2:0] {ACC_W, ACC_H, ACC_M, ACC_R, ACC_G, ACC_B} acc_sel_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_PIXEL  = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_HEADER  = 3'd1,
		ST_UNSUPPORTED = 3'd2,
		ST_BAD_PIXEL   = 3'd3,
		ST_TRUNCATED   = 3'd4,
		ST_TOO_LARGE   = 3'd5
	} status_t;

	typedef enum logic [1:0] {FMT_P2 = 2'd0, FMT_P3 = 2'd1, FMT_P6 = 2'd2} fmt_t;

	typedef enum logic [1:0] {PIX_NONE, PIX_RAW, PIX_SCALED} pix_src_t;

	typedef struct packed {
		logic     clear;
		logic     fmt_wr;
		fmt_t     fmt;
		logic     dig_wr;
		acc_sel_t dig_sel;
		logic     raw_wr;
		logic     raw_green;
		logic     emit;
		kind_t    kind;
		status_t  status;
		pix_src_t pix_src;
		logic     div_start;
		logic [1:0] div_ch;
	} dp_cmd_t;

	typedef struct packed {
		logic ovf;
		logic hdr_zero;
		logic pix_last;
		logic div_done;
		logic out_full;
		fmt_t fmt;
	} dp_sts_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

endpackage

FILE: hw/rtl/ppmd_div.sv
// Bit-serial restoring divider for sample scaling: quotient of num*255/den,
// low eight bits. Depends on nothing but its parameter.
module ppmd_div #(
	parameter int NUMBER_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUMBER_BITS-1:0] num,
	input  logic [NUMBER_BITS-1:0] den,
	output logic                   done,
	output logic [7:0]             quo
);
	localparam int NW = NUMBER_BITS + 8;
	localparam int CW = $clog2(NW + 1);

	logic                   busy_q, done_q;
	logic [CW-1:0]          cnt_q;
	logic [NW-1:0]          n_q;
	logic [NUMBER_BITS-1:0] rem_q;
	logic [7:0]             q_q;
	logic [NUMBER_BITS:0]   rem_sh, diff;
	logic                   ge;

	assign rem_sh = {rem_q, n_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den};
	assign diff   = rem_sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {num, 8'd0} - NW'(num);
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			rem_q <= ge ? diff[NUMBER_BITS-1:0] : rem_sh[NUMBER_BITS-1:0];
			q_q   <= {q_q[6:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule

FILE: hw/rtl/ppmd_dp.sv
// Datapath: header values, sample accumulators, pixel counters, scaling
// divider and output register. Depends on ppmd_pkg and ppmd_div.
module ppmd_dp #(
	parameter int NUMBER_BITS = ppmd_pkg::NUMBER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        in_tdata,
	input  ppmd_pkg::dp_cmd_t                 cmd,
	output ppmd_pkg::dp_sts_t                 sts,
	output logic                              out_tvalid,
	input  logic                              out_tready,
	output logic [ppmd_pkg::OUT_DATA_W-1:0]   out_tdata,
	output logic [1:0]                        out_tuser,
	output logic                              out_tlast
);
	localparam int NB = NUMBER_BITS;

	ppmd_pkg::fmt_t  fmt_q;
	logic [NB-1:0]   w_q, h_q, m_q, r_q, g_q, b_q, col_q, row_q;
	logic [7:0]      sc_r_q, sc_g_q;
	logic [NB-1:0]   acc_cur, col_inc, row_inc, div_num, div_den;
	logic [NB+3:0]   ext, prod;
	logic            wrap, pix_last, div_done;
	logic [7:0]      div_quo;

	ppmd_pkg::kind_t   kind_q;
	ppmd_pkg::status_t status_q;
	logic              valid_q, last_q;
	logic [7:0]        red_q, green_q, blue_q;
	logic [15:0]       ocol_q, orow_q, ow_q, oh_q, om_q;
	logic [1:0]        ofmt_q;

	always_comb begin
		case (cmd.dig_sel)
			ppmd_pkg::ACC_W: acc_cur = w_q;
			ppmd_pkg::ACC_H: acc_cur = h_q;
			ppmd_pkg::ACC_M: acc_cur = m_q;
			ppmd_pkg::ACC_R: acc_cur = r_q;
			ppmd_pkg::ACC_G: acc_cur = g_q;
			ppmd_pkg::ACC_B: acc_cur = b_q;
			default:         acc_cur = w_q;
		endcase
	end

	assign ext      = (NB+4)'(acc_cur);
	assign prod     = (ext << 3) + (ext << 1) + (NB+4)'(in_tdata[3:0]);
	assign col_inc  = col_q + 1'b1;
	assign row_inc  = row_q + 1'b1;
	assign wrap     = col_inc >= w_q;
	assign pix_last = wrap && (row_inc >= h_q);

	always_comb begin
		case (cmd.div_ch)
			2'd0:    div_num = r_q;
			2'd1:    div_num = g_q;
			default: div_num = b_q;
		endcase
	end
	assign div_den = (m_q == '0) ? NB'(1) : m_q;

	ppmd_div #(.NUMBER_BITS(NB)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_comb begin
		sts.ovf      = |prod[NB+3:NB];
		sts.hdr_zero = (w_q == '0) || (h_q == '0) || (m_q == '0);
		sts.pix_last = pix_last;
		sts.div_done = div_done;
		sts.out_full = valid_q;
		sts.fmt      = fmt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= ppmd_pkg::FMT_P2;
			w_q   <= '0;
			h_q   <= '0;
			m_q   <= '0;
			r_q   <= '0;
			g_q   <= '0;
			b_q   <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.clear) begin
			fmt_q <= ppmd_pkg::FMT_P2;
			w_q   <= '0;
			h_q   <= '0;
			m_q   <= '0;
			r_q   <= '0;
			g_q   <= '0;
			b_q   <= '0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (cmd.fmt_wr)
				fmt_q <= cmd.fmt;
			if (cmd.dig_wr) begin
				case (cmd.dig_sel)
					ppmd_pkg::ACC_W: w_q <= prod[NB-1:0];
					ppmd_pkg::ACC_H: h_q <= prod[NB-1:0];
					ppmd_pkg::ACC_M: m_q <= prod[NB-1:0];
					ppmd_pkg::ACC_R: r_q <= prod[NB-1:0];
					ppmd_pkg::ACC_G: g_q <= prod[NB-1:0];
					ppmd_pkg::ACC_B: b_q <= prod[NB-1:0];
					default: ;
				endcase
			end
			if (cmd.raw_wr) begin
				if (cmd.raw_green)
					g_q <= NB'(in_tdata);
				else
					r_q <= NB'(in_tdata);
			end
			if (cmd.emit && (cmd.pix_src != ppmd_pkg::PIX_NONE)) begin
				if (wrap) begin
					col_q <= '0;
					row_q <= row_inc;
				end else begin
					col_q <= col_inc;
				end
			end
			if (cmd.emit && (cmd.pix_src == ppmd_pkg::PIX_SCALED)) begin
				r_q <= '0;
				g_q <= '0;
				b_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_ch)
				2'd0:    sc_r_q <= div_quo;
				2'd1:    sc_g_q <= div_quo;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.kind;
			status_q <= cmd.status;
			ow_q     <= 16'(w_q);
			oh_q     <= 16'(h_q);
			om_q     <= 16'(m_q);
			ofmt_q   <= fmt_q;
			case (cmd.pix_src)
				ppmd_pkg::PIX_RAW: begin
					red_q   <= r_q[7:0];
					green_q <= g_q[7:0];
					blue_q  <= in_tdata;
				end
				ppmd_pkg::PIX_SCALED: begin
					red_q   <= sc_r_q;
					green_q <= sc_g_q;
					blue_q  <= div_quo;
				end
				default: begin
					red_q   <= '0;
					green_q <= '0;
					blue_q  <= '0;
				end
			endcase
			if (cmd.pix_src != ppmd_pkg::PIX_NONE) begin
				ocol_q <= 16'(col_q);
				orow_q <= 16'(row_q);
				last_q <= pix_last;
			end else begin
				ocol_q <= '0;
				orow_q <= '0;
				last_q <= 1'b0;
			end
		end
	end

	assign out_tvalid = valid_q;
	assign out_tuser  = kind_q;
	assign out_tlast  = last_q;
	assign out_tdata  = {3'd0, ofmt_q, om_q, oh_q, ow_q, orow_q, ocol_q,
		blue_q, green_q, red_q, status_q};
endmodule

FILE: hw/rtl/ppmd_ctrl.sv
// Controller: header and body parse state machine, scaling sequencer and
// input handshake. Depends on ppmd_pkg; drives the datapath by commands.
module ppmd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_tvalid,
	output logic              in_tready,
	input  logic [7:0]        in_tdata,
	input  logic              in_tlast,
	input  ppmd_pkg::dp_sts_t sts,
	output ppmd_pkg::dp_cmd_t cmd
);
	ppmd_pkg::phase_t     phase_q, resume_q, phase_d, resume_d, hdr_res, pix_res;
	ppmd_pkg::ctl_state_t state_q, state_d;
	ppmd_pkg::acc_sel_t   tgt;
	ppmd_pkg::status_t    fail_st;
	ppmd_pkg::dp_cmd_t    bc;
	logic                 stopped_q, stop_d, scaled_last;
	logic [1:0]           raw_q, raw_d, ch_q;
	logic                 accept, go_scale, fail_en, hd;

	assign accept    = in_tvalid && in_tready;
	assign in_tready = (state_q == ppmd_pkg::CS_IDLE) && !sts.out_full;

	always_comb begin
		hdr_res = (resume_q inside {[ppmd_pkg::PH_WIDTH:ppmd_pkg::PH_MAXVAL]}) ?
			resume_q : ppmd_pkg::PH_WIDTH;
		pix_res = (resume_q inside {[ppmd_pkg::PH_RED:ppmd_pkg::PH_BLUE]}) ?
			resume_q : ppmd_pkg::PH_RED;
		case (phase_q)
			ppmd_pkg::PH_HEIGHT: tgt = ppmd_pkg::ACC_H;
			ppmd_pkg::PH_MAXVAL: tgt = ppmd_pkg::ACC_M;
			ppmd_pkg::PH_RED:    tgt = ppmd_pkg::ACC_R;
			ppmd_pkg::PH_GREEN:  tgt = ppmd_pkg::ACC_G;
			ppmd_pkg::PH_BLUE:   tgt = ppmd_pkg::ACC_B;
			ppmd_pkg::PH_SKIP: begin
				case (hdr_res)
					ppmd_pkg::PH_HEIGHT: tgt = ppmd_pkg::ACC_H;
					ppmd_pkg::PH_MAXVAL: tgt = ppmd_pkg::ACC_M;
					default:             tgt = ppmd_pkg::ACC_W;
				endcase
			end
			ppmd_pkg::PH_PIXSKIP: begin
				case (pix_res)
					ppmd_pkg::PH_GREEN: tgt = ppmd_pkg::ACC_G;
					ppmd_pkg::PH_BLUE:  tgt = ppmd_pkg::ACC_B;
					default:            tgt = ppmd_pkg::ACC_R;
				endcase
			end
			default: tgt = ppmd_pkg::ACC_W;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		resume_d = resume_q;
		stop_d   = stopped_q;
		raw_d    = raw_q;
		go_scale = 1'b0;
		fail_en  = 1'b0;
		fail_st  = ppmd_pkg::ST_BAD_HEADER;
		hd       = 1'b0;
		bc       = '0;
		bc.dig_sel = tgt;
		if (accept && in_tlast) begin
			if (!stopped_q) begin
				bc.emit = 1'b1;
				bc.kind = ppmd_pkg::KIND_STATUS;
				if (phase_q inside {[ppmd_pkg::PH_PIXSKIP:ppmd_pkg::PH_BLUE]})
					bc.status = ppmd_pkg::ST_TRUNCATED;
				else if (phase_q == ppmd_pkg::PH_RAW)
					bc.status = ppmd_pkg::ST_OK;
				else
					bc.status = ppmd_pkg::ST_BAD_HEADER;
			end
			bc.clear = 1'b1;
			phase_d  = ppmd_pkg::PH_BEGIN;
			resume_d = ppmd_pkg::PH_WIDTH;
			stop_d   = 1'b0;
			raw_d    = '0;
		end else if (accept && !stopped_q) begin
			case (phase_q)
				ppmd_pkg::PH_BEGIN: begin
					if (in_tdata != ppmd_pkg::CH_P)
						fail_en = 1'b1;
					else
						phase_d = ppmd_pkg::PH_FORMAT;
				end
				ppmd_pkg::PH_FORMAT: begin
					bc.fmt_wr = 1'b1;
					resume_d  = ppmd_pkg::PH_WIDTH;
					phase_d   = ppmd_pkg::PH_SKIP;
					if (in_tdata == ppmd_pkg::CH_2)
						bc.fmt = ppmd_pkg::FMT_P2;
					else if (in_tdata == ppmd_pkg::CH_3)
						bc.fmt = ppmd_pkg::FMT_P3;
					else if (in_tdata == ppmd_pkg::CH_6)
						bc.fmt = ppmd_pkg::FMT_P6;
					else begin
						bc.fmt_wr = 1'b0;
						phase_d   = phase_q;
						resume_d  = resume_q;
						fail_en   = 1'b1;
					end
				end
				ppmd_pkg::PH_WIDTH, ppmd_pkg::PH_HEIGHT, ppmd_pkg::PH_MAXVAL: begin
					if (ppmd_pkg::is_dig(in_tdata)) begin
						if (sts.ovf) begin
							fail_en = 1'b1;
							fail_st = ppmd_pkg::ST_TOO_LARGE;
						end else begin
							bc.dig_wr = 1'b1;
						end
					end else if (!ppmd_pkg::is_ws(in_tdata)) begin
						fail_en = 1'b1;
					end else if (phase_q == ppmd_pkg::PH_MAXVAL) begin
						if (in_tdata == ppmd_pkg::CH_NL)
							hd = 1'b1;
						else
							phase_d = ppmd_pkg::PH_EOL;
					end else begin
						resume_d = (phase_q == ppmd_pkg::PH_WIDTH) ?
							ppmd_pkg::PH_HEIGHT : ppmd_pkg::PH_MAXVAL;
						phase_d  = ppmd_pkg::PH_SKIP;
					end
				end
				ppmd_pkg::PH_EOL: begin
					if (in_tdata == ppmd_pkg::CH_NL)
						hd = 1'b1;
					else if (!ppmd_pkg::is_ws(in_tdata))
						fail_en = 1'b1;
				end
				ppmd_pkg::PH_SKIP: begin
					if (ppmd_pkg::is_ws(in_tdata)) begin
						phase_d = phase_q;
					end else if (in_tdata == ppmd_pkg::CH_HASH) begin
						phase_d = ppmd_pkg::PH_COMMENT;
					end else if (!ppmd_pkg::is_dig(in_tdata)) begin
						fail_en = 1'b1;
					end else begin
						resume_d = hdr_res;
						phase_d  = hdr_res;
						if (sts.ovf) begin
							fail_en = 1'b1;
							fail_st = ppmd_pkg::ST_TOO_LARGE;
						end else begin
							bc.dig_wr = 1'b1;
						end
					end
				end
				ppmd_pkg::PH_COMMENT: begin
					if (in_tdata == ppmd_pkg::CH_NL)
						phase_d = ppmd_pkg::PH_SKIP;
				end
				ppmd_pkg::PH_PIXSKIP: begin
					if (ppmd_pkg::is_ws(in_tdata)) begin
						phase_d = phase_q;
					end else if (!ppmd_pkg::is_dig(in_tdata)) begin
						fail_en = 1'b1;
						fail_st = ppmd_pkg::ST_BAD_PIXEL;
					end else begin
						resume_d = pix_res;
						phase_d  = pix_res;
						if (sts.ovf) begin
							fail_en = 1'b1;
							fail_st = ppmd_pkg::ST_TOO_LARGE;
						end else begin
							bc.dig_wr = 1'b1;
						end
					end
				end
				ppmd_pkg::PH_RED, ppmd_pkg::PH_GREEN, ppmd_pkg::PH_BLUE: begin
					if (ppmd_pkg::is_dig(in_tdata)) begin
						if (sts.ovf) begin
							fail_en = 1'b1;
							fail_st = ppmd_pkg::ST_TOO_LARGE;
						end else begin
							bc.dig_wr = 1'b1;
						end
					end else if (!ppmd_pkg::is_ws(in_tdata)) begin
						fail_en = 1'b1;
						fail_st = ppmd_pkg::ST_BAD_PIXEL;
					end else if (phase_q == ppmd_pkg::PH_BLUE) begin
						resume_d = ppmd_pkg::PH_RED;
						phase_d  = ppmd_pkg::PH_PIXSKIP;
						go_scale = 1'b1;
					end else begin
						resume_d = (phase_q == ppmd_pkg::PH_RED) ?
							ppmd_pkg::PH_GREEN : ppmd_pkg::PH_BLUE;
						phase_d  = ppmd_pkg::PH_PIXSKIP;
					end
				end
				ppmd_pkg::PH_RAW: begin
					if (raw_q == 2'd0) begin
						bc.raw_wr = 1'b1;
						raw_d     = 2'd1;
					end else if (raw_q == 2'd1) begin
						bc.raw_wr    = 1'b1;
						bc.raw_green = 1'b1;
						raw_d        = 2'd2;
					end else begin
						raw_d      = 2'd0;
						bc.emit    = 1'b1;
						bc.kind    = ppmd_pkg::KIND_PIXEL;
						bc.pix_src = ppmd_pkg::PIX_RAW;
						if (sts.pix_last)
							stop_d = 1'b1;
					end
				end
				default: fail_en = 1'b1;
			endcase
			if (hd) begin
				if (sts.hdr_zero) begin
					fail_en = 1'b1;
				end else if (sts.fmt == ppmd_pkg::FMT_P2) begin
					fail_en = 1'b1;
					fail_st = ppmd_pkg::ST_UNSUPPORTED;
				end else begin
					bc.emit  = 1'b1;
					bc.kind  = ppmd_pkg::KIND_HEADER;
					phase_d  = (sts.fmt == ppmd_pkg::FMT_P6) ?
						ppmd_pkg::PH_RAW : ppmd_pkg::PH_PIXSKIP;
					resume_d = (sts.fmt == ppmd_pkg::FMT_P3) ?
						ppmd_pkg::PH_RED : ppmd_pkg::PH_RAW;
				end
			end
			if (fail_en) begin
				bc.emit   = 1'b1;
				bc.kind   = ppmd_pkg::KIND_STATUS;
				bc.status = fail_st;
				stop_d    = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppmd_pkg::CS_IDLE:  if (go_scale) state_d = ppmd_pkg::CS_START;
			ppmd_pkg::CS_START: state_d = ppmd_pkg::CS_WAIT;
			ppmd_pkg::CS_WAIT: begin
				if (sts.div_done)
					state_d = (ch_q == 2'd2) ? ppmd_pkg::CS_IDLE : ppmd_pkg::CS_START;
			end
			default: state_d = ppmd_pkg::CS_IDLE;
		endcase
	end

	always_comb begin
		cmd         = bc;
		cmd.div_ch  = ch_q;
		scaled_last = 1'b0;
		case (state_q)
			ppmd_pkg::CS_START: cmd.div_start = 1'b1;
			ppmd_pkg::CS_WAIT: begin
				if (sts.div_done && (ch_q == 2'd2)) begin
					cmd.emit    = 1'b1;
					cmd.kind    = ppmd_pkg::KIND_PIXEL;
					cmd.pix_src = ppmd_pkg::PIX_SCALED;
					scaled_last = sts.pix_last;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ppmd_pkg::PH_BEGIN;
			resume_q  <= ppmd_pkg::PH_WIDTH;
			stopped_q <= 1'b0;
			raw_q     <= '0;
			state_q   <= ppmd_pkg::CS_IDLE;
			ch_q      <= '0;
		end else begin
			phase_q   <= phase_d;
			resume_q  <= resume_d;
			stopped_q <= stop_d | scaled_last;
			raw_q     <= raw_d;
			state_q   <= state_d;
			if (state_q == ppmd_pkg::CS_IDLE)
				ch_q <= '0;
			else if ((state_q == ppmd_pkg::CS_WAIT) && sts.div_done)
				ch_q <= ch_q + 1'b1;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_full)
		else $error("result issued while output register full");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ppmd_pkg::CS_WAIT))
		else $error("divider finished outside wait state");

	a_stopped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(stopped_q && !(accept && in_tlast)) |-> !cmd.emit)
		else $error("result issued while stopped");

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ppmd_pkg::CS_IDLE) |-> (ch_q != 2'd3))
		else $error("scaling channel out of range");
endmodule

FILE: hw/rtl/ppm_stream_decoder.sv
// PPM stream decoder, top level: joins the parse controller and the datapath.
// Depends on ppmd_pkg, ppmd_ctrl and ppmd_dp.
// One byte is taken per cycle while the output register is empty and no
// scaling is in progress. The byte that closes a P3 pixel starts three
// divisions in turn on one shared bit-serial divider, and no further byte is
// taken until all three are done. P6 pixels and header bytes need no
// division.
module ppm_stream_decoder #(
	parameter int NUMBER_BITS = ppmd_pkg::NUMBER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_tvalid,
	output logic                            in_tready,
	input  logic [7:0]                      in_tdata,   // data_byte
	input  logic                            in_tlast,
	output logic                            out_tvalid,
	input  logic                            out_tready,
	// status, red, green, blue, column, row, image_width, image_height,
	// max_value, format_code, zero fill
	output logic [ppmd_pkg::OUT_DATA_W-1:0] out_tdata,
	output logic [1:0]                      out_tuser,  // kind
	output logic                            out_tlast
);
	ppmd_pkg::dp_cmd_t cmd;
	ppmd_pkg::dp_sts_t sts;

	ppmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tvalid(in_tvalid),
		.in_tready(in_tready),
		.in_tdata (in_tdata),
		.in_tlast (in_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppmd_dp #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tdata  (in_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_tvalid(out_tvalid),
		.out_tready(out_tready),
		.out_tdata (out_tdata),
		.out_tuser (out_tuser),
		.out_tlast (out_tlast)
	);
endmodule

FILE: verif/testbench.sv
// Self-checking testbench for ppm_stream_decoder: drives PPM byte streams over the
// input stream and checks every output transfer against a built-in parser model.
// Depends on ppmd_pkg and the ppm_stream_decoder RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int QUIET_TAIL  = 150;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  status;
		logic [7:0]  red, green, blue;
		logic [15:0] column, row;
		logic        last;
		logic [15:0] width, height, maxval;
		logic [1:0]  fmt;
	} ppm_result_t;

	class ppm_scoreboard;
		ppmd_pkg::phase_t phase, resume;
		logic [1:0]  fmt;
		int unsigned acc[6];
		int unsigned col, row, raw_idx;
		bit          stopped;
		ppm_result_t pending[$];
		int          errors;

		function void restart();
			phase = ppmd_pkg::PH_BEGIN;
			resume = ppmd_pkg::PH_WIDTH;
			fmt = ppmd_pkg::FMT_P2;
			foreach (acc[i]) acc[i] = 0;
			col = 0;
			row = 0;
			raw_idx = 0;
			stopped = 0;
		endfunction

		function void push(logic [1:0] k, logic [2:0] st, int unsigned r = 0,
				int unsigned g = 0, int unsigned b = 0, int unsigned c = 0,
				int unsigned rw = 0, bit last = 0);
			ppm_result_t e;
			e.kind = k;
			e.status = st;
			e.red = r[7:0];
			e.green = g[7:0];
			e.blue = b[7:0];
			e.column = c[15:0];
			e.row = rw[15:0];
			e.last = last;
			e.width = acc[0][15:0];
			e.height = acc[1][15:0];
			e.maxval = acc[2][15:0];
			e.fmt = fmt;
			pending.push_back(e);
		endfunction

		function void halt(logic [2:0] st);
			stopped = 1;
			push(ppmd_pkg::KIND_STATUS, st);
		endfunction

		// false on overflow past 16 bits
		function bit add_digit(int idx, logic [7:0] c);
			longint unsigned v;
			v = longint'(acc[idx]) * 10 + (c - 8'h30);
			if (v > 65535) return 0;
			acc[idx] = int'(v);
			return 1;
		endfunction

		function int unsigned scaled(int unsigned v);
			longint unsigned m;
			m = (acc[2] != 0) ? acc[2] : 1;
			return int'((longint'(v) * 255) / m) & 8'hFF;
		endfunction

		function void pixel(int unsigned r, int unsigned g, int unsigned b);
			int unsigned c, rw;
			bit last;
			c = col;
			rw = row;
			last = 0;
			col++;
			if (col >= acc[0]) begin
				col = 0;
				row++;
				if (row >= acc[1]) begin
					last = 1;
					stopped = 1;
				end
			end
			push(ppmd_pkg::KIND_PIXEL, ppmd_pkg::ST_OK, r, g, b, c, rw, last);
		endfunction

		function void header_done();
			if (acc[0] == 0 || acc[1] == 0 || acc[2] == 0) halt(ppmd_pkg::ST_BAD_HEADER);
			else if (fmt == ppmd_pkg::FMT_P2) halt(ppmd_pkg::ST_UNSUPPORTED);
			else begin
				phase = (fmt == ppmd_pkg::FMT_P6) ? ppmd_pkg::PH_RAW : ppmd_pkg::PH_PIXSKIP;
				resume = (fmt == ppmd_pkg::FMT_P3) ? ppmd_pkg::PH_RED : ppmd_pkg::PH_RAW;
				push(ppmd_pkg::KIND_HEADER, ppmd_pkg::ST_OK);
			end
		endfunction

		function void note(logic [7:0] c, logic eos);
			if (eos) begin
				if (!stopped) begin
					if (phase >= ppmd_pkg::PH_PIXSKIP && phase <= ppmd_pkg::PH_BLUE)
						push(ppmd_pkg::KIND_STATUS, ppmd_pkg::ST_TRUNCATED);
					else if (phase == ppmd_pkg::PH_RAW)
						push(ppmd_pkg::KIND_STATUS, ppmd_pkg::ST_OK);
					else
						push(ppmd_pkg::KIND_STATUS, ppmd_pkg::ST_BAD_HEADER);
				end
				restart();
				return;
			end
			if (stopped) return;
			case (phase)
				ppmd_pkg::PH_BEGIN: begin
					if (c != ppmd_pkg::CH_P) halt(ppmd_pkg::ST_BAD_HEADER);
					else phase = ppmd_pkg::PH_FORMAT;
				end
				ppmd_pkg::PH_FORMAT: begin
					if (c == ppmd_pkg::CH_2 || c == ppmd_pkg::CH_3 || c == ppmd_pkg::CH_6) begin
						fmt = (c == ppmd_pkg::CH_2) ? ppmd_pkg::FMT_P2 :
							(c == ppmd_pkg::CH_3) ? ppmd_pkg::FMT_P3 : ppmd_pkg::FMT_P6;
						resume = ppmd_pkg::PH_WIDTH;
						phase = ppmd_pkg::PH_SKIP;
					end else halt(ppmd_pkg::ST_BAD_HEADER);
				end
				ppmd_pkg::PH_WIDTH, ppmd_pkg::PH_HEIGHT, ppmd_pkg::PH_MAXVAL: begin
					if (ppmd_pkg::is_dig(c)) begin
						if (!add_digit(phase - ppmd_pkg::PH_WIDTH, c))
							halt(ppmd_pkg::ST_TOO_LARGE);
					end else if (!ppmd_pkg::is_ws(c)) halt(ppmd_pkg::ST_BAD_HEADER);
					else if (phase == ppmd_pkg::PH_MAXVAL) begin
						if (c == ppmd_pkg::CH_NL) header_done();
						else phase = ppmd_pkg::PH_EOL;
					end else begin
						resume = ppmd_pkg::phase_t'(phase + 1);
						phase = ppmd_pkg::PH_SKIP;
					end
				end
				ppmd_pkg::PH_EOL: begin
					if (c == ppmd_pkg::CH_NL) header_done();
					else if (!ppmd_pkg::is_ws(c)) halt(ppmd_pkg::ST_BAD_HEADER);
				end
				ppmd_pkg::PH_SKIP: begin
					if (c == ppmd_pkg::CH_HASH) phase = ppmd_pkg::PH_COMMENT;
					else if (!ppmd_pkg::is_ws(c)) begin
						if (!ppmd_pkg::is_dig(c)) halt(ppmd_pkg::ST_BAD_HEADER);
						else begin
							if (resume < ppmd_pkg::PH_WIDTH || resume > ppmd_pkg::PH_MAXVAL)
								resume = ppmd_pkg::PH_WIDTH;
							phase = resume;
							if (!add_digit(phase - ppmd_pkg::PH_WIDTH, c))
								halt(ppmd_pkg::ST_TOO_LARGE);
						end
					end
				end
				ppmd_pkg::PH_COMMENT: if (c == ppmd_pkg::CH_NL) phase = ppmd_pkg::PH_SKIP;
				ppmd_pkg::PH_PIXSKIP: begin
					if (!ppmd_pkg::is_ws(c)) begin
						if (!ppmd_pkg::is_dig(c)) halt(ppmd_pkg::ST_BAD_PIXEL);
						else begin
							if (resume < ppmd_pkg::PH_RED || resume > ppmd_pkg::PH_BLUE)
								resume = ppmd_pkg::PH_RED;
							phase = resume;
							if (!add_digit(phase - ppmd_pkg::PH_RED + 3, c))
								halt(ppmd_pkg::ST_TOO_LARGE);
						end
					end
				end
				ppmd_pkg::PH_RED, ppmd_pkg::PH_GREEN, ppmd_pkg::PH_BLUE: begin
					if (ppmd_pkg::is_dig(c)) begin
						if (!add_digit(phase - ppmd_pkg::PH_RED + 3, c))
							halt(ppmd_pkg::ST_TOO_LARGE);
					end else if (!ppmd_pkg::is_ws(c)) halt(ppmd_pkg::ST_BAD_PIXEL);
					else if (phase != ppmd_pkg::PH_BLUE) begin
						resume = ppmd_pkg::phase_t'(phase + 1);
						phase = ppmd_pkg::PH_PIXSKIP;
					end else begin
						int unsigned r, g, b;
						r = scaled(acc[3]);
						g = scaled(acc[4]);
						b = scaled(acc[5]);
						acc[3] = 0;
						acc[4] = 0;
						acc[5] = 0;
						resume = ppmd_pkg::PH_RED;
						phase = ppmd_pkg::PH_PIXSKIP;
						pixel(r, g, b);
					end
				end
				ppmd_pkg::PH_RAW: begin
					if (raw_idx == 0) begin
						acc[3] = c;
						raw_idx = 1;
					end else if (raw_idx == 1) begin
						acc[4] = c;
						raw_idx = 2;
					end else begin
						raw_idx = 0;
						pixel(acc[3], acc[4], c);
					end
				end
				default: halt(ppmd_pkg::ST_BAD_HEADER);
			endcase
		endfunction

		function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
			if (exp_v != act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check(logic [ppmd_pkg::OUT_DATA_W-1:0] d, logic [1:0] k, logic last);
			ppm_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transfer, kind %0d", k);
				errors++;
				return;
			end
			e = pending.pop_front();
			compare("kind", e.kind, k);
			compare("status", e.status, d[2:0]);
			compare("red", e.red, d[10:3]);
			compare("green", e.green, d[18:11]);
			compare("blue", e.blue, d[26:19]);
			compare("column", e.column, d[42:27]);
			compare("row", e.row, d[58:43]);
			compare("last_pixel", e.last, last);
			compare("image_width", e.width, d[74:59]);
			compare("image_height", e.height, d[90:75]);
			compare("max_value", e.maxval, d[106:91]);
			compare("format_code", e.fmt, d[108:107]);
		endfunction
	endclass

	logic                            clk, arst_n;
	logic                            in_tvalid, in_tready, in_tlast;
	logic [7:0]                      in_tdata;
	logic                            out_tvalid, out_tready, out_tlast;
	logic [ppmd_pkg::OUT_DATA_W-1:0] out_tdata;
	logic [1:0]                      out_tuser;

	ppm_stream_decoder uut (.*);

	ppm_scoreboard decoder_model = new();
	logic [8:0]    stream_bytes[$];
	bit            quiet;
	int            stall_count;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic void put_str(string s);
		foreach (s[i]) stream_bytes.push_back({1'b0, s[i]});
	endfunction

	function automatic void put_byte(logic [7:0] b);
		stream_bytes.push_back({1'b0, b});
	endfunction

	function automatic void put_eos();
		stream_bytes.push_back({1'b1, 8'($urandom)});
	endfunction

	function automatic string gap();
		case ($urandom_range(0, 9))
			0: return "\t";
			1: return "\n";
			2: return " \r\n";
			3: return "\v\f ";
			4: return " # note\n";
			default: return " ";
		endcase
	endfunction

	function automatic void put_image();
		int unsigned w, h, m, sel, cut, n;
		bit p6;
		sel = $urandom_range(0, 19);
		if (sel < 2) begin
			n = $urandom_range(1, 12);
			repeat (n) put_byte(8'($urandom));
			put_eos();
			return;
		end
		p6 = sel < 8;
		w = $urandom_range(1, 4);
		h = $urandom_range(1, 3);
		case ($urandom_range(0, 3))
			0: m = 1;
			1: m = 255;
			2: m = 65535;
			default: m = $urandom_range(1, 1000);
		endcase
		put_str(sel == 2 ? "P2" : (p6 ? "P6" : "P3"));
		put_str($sformatf("%s%0d%s%0d%s%0d", gap(), w, gap(), h, gap(), m));
		put_str($urandom_range(0, 3) == 0 ? " \t\n" : "\n");
		cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, w * h * 3) : w * h * 3 + 1;
		for (int i = 0; i < w * h * 3 && i < cut; i++) begin
			if (p6) put_byte(8'($urandom));
			else if ($urandom_range(0, 40) == 0) put_str("z ");
			else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, m);
				put_str($sformatf("%0d%s", n, gap() == "\t" ? "\t" : " "));
			end
		end
		if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
		put_eos();
	endfunction

	task automatic drive_stream();
		logic [8:0] item;
		while (stream_bytes.size() != 0) begin
			item = stream_bytes.pop_front();
			quiet = stream_bytes.size() < QUIET_TAIL;
			if (!quiet && $urandom_range(0, 5) == 0) begin
				in_tvalid = 0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			in_tvalid = 1;
			in_tdata = item[7:0];
			in_tlast = item[8];
			do @(posedge clk); while (!in_tready);
			@(negedge clk);
		end
		in_tvalid = 0;
	endtask

	initial begin
		out_tready = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_tready = 0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			out_tready = 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_tvalid && in_tready) decoder_model.note(in_tdata, in_tlast);
			if (out_tvalid && out_tready) decoder_model.check(out_tdata, out_tuser, out_tlast);
			if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_count = 0;
			else stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 0;
		in_tvalid = 0;
		in_tdata = 0;
		in_tlast = 0;
		quiet = 0;
		stall_count = 0;
		decoder_model.restart();
		put_str("P3\n# c\n2 1\n255\n0 255 128 1 2 3\n");
		put_eos();
		put_str("P6\n1 1\n1\n");
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'hAA);
		put_str("junk");
		put_eos();
		put_str("P2 1 1 255\n");
		put_eos();
		put_str("X");
		put_eos();
		put_str("P7");
		put_eos();
		put_str("P3 0 1 255\n");
		put_eos();
		put_str("P3 65536");
		put_eos();
		put_str("P3 1 1 10 \n20 x");
		put_eos();
		put_str("P3 1 2 65535\n1 2 3\n");
		put_eos();
		put_str("P6 2 1 255\n");
		repeat (4) put_byte(8'($urandom));
		put_eos();
		put_str("P3 1 1 255\n99999");
		put_eos();
		put_str("P3 #c\n1");
		put_eos();
		put_str("P3 1 1 255x");
		put_eos();
		while (stream_bytes.size() < 1380) put_image();
		repeat (8) @(negedge clk);
		arst_n = 1;
		drive_stream();
		while (decoder_model.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (decoder_model.errors == 0 && decoder_model.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

FILE: sim.f
hw/rtl/ppmd_pkg.sv
hw/rtl/ppmd_div.sv
hw/rtl/ppmd_dp.sv
hw/rtl/ppmd_ctrl.sv
hw/rtl/ppm_stream_decoder.sv
verif/testbench.sv
